>>> sv/string_literal_unescape_macros.svh
// Assertion macros shared by the string literal unescape RTL.
`ifndef STRING_LITERAL_UNESCAPE_MACROS_SVH
`define STRING_LITERAL_UNESCAPE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SLU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the following edge.
`define SLU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/slu_pkg.sv
// Types, character codes and helper functions for the string literal unescape block.
`default_nettype none

package slu_pkg;

    // Result kinds carried on the output tuser
    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_END    = 2'd1,
        KIND_NOTLIT = 2'd2
    } t_kind;

    // One result word
    typedef struct packed {
        logic [7:0] dbyte;
        t_kind      kind;
        logic       last;
    } t_res;

    // Results handed together from the decoder to the result queue
    typedef struct packed {
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_push;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    // Control characters produced by escapes
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_VT = 8'h0B;

    // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

endpackage

`default_nettype wire

>>> sv/slu_decode.sv
// Input register, escape state and single-pass decode of one text byte.
`default_nettype none

module slu_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_text,
    input  wire logic          i_start,
    input  wire logic          i_room,
    output slu_pkg::t_push     o_push
);
    import slu_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_OCT1 = 3'd5,
        PH_OCT2 = 3'd6
    } t_phase;

    logic       r_in_valid;
    logic [7:0] r_text;
    logic       r_start;
    t_phase     r_phase, n_phase;
    logic [7:0] r_acc, n_acc;

    logic       fire;
    logic       pre_emit;
    t_res       pre_res;
    logic       use_body;
    logic       b_emit;
    t_res       b_res;
    t_phase     b_phase;
    logic       b_clr;
    logic [4:0] hx;
    logic       oct;
    t_push      push;

    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || fire;
    assign hx      = hex_digit(r_text);
    assign oct     = is_octal(r_text);

    // Handle an ordinary body byte
    always_comb begin
        b_emit  = 1'b0;
        b_res   = '{dbyte: 8'd0, kind: KIND_BYTE, last: 1'b0};
        b_phase = PH_BODY;
        b_clr   = 1'b0;
        if (r_text == CH_BSLASH) begin
            b_phase = PH_ESC;
        end else if (r_text == CH_DQUOTE || r_text == CH_NUL) begin
            b_emit  = 1'b1;
            b_res   = '{dbyte: 8'd0, kind: KIND_END, last: 1'b1};
            b_phase = PH_IDLE;
            b_clr   = 1'b1;
        end else begin
            b_emit = 1'b1;
            b_res  = '{dbyte: r_text, kind: KIND_BYTE, last: 1'b0};
        end
    end

    // Advance the phase; a pending escape may emit before the body byte
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        pre_emit = 1'b0;
        pre_res  = '{dbyte: 8'd0, kind: KIND_BYTE, last: 1'b0};
        use_body = 1'b0;
        if (r_start) begin
            n_acc = 8'd0;
            if (r_text == CH_DQUOTE) begin
                n_phase = PH_BODY;
            end else begin
                n_phase  = PH_IDLE;
                pre_emit = 1'b1;
                pre_res  = '{dbyte: 8'd0, kind: KIND_NOTLIT, last: 1'b1};
            end
        end else begin
            case (r_phase)
                PH_BODY: begin
                    use_body = 1'b1;
                end
                PH_ESC: begin
                    pre_res = '{dbyte: 8'd0, kind: KIND_BYTE, last: 1'b0};
                    case (r_text)
                        CH_N:      begin pre_emit = 1'b1; pre_res.dbyte = CTL_LF; end
                        CH_R:      begin pre_emit = 1'b1; pre_res.dbyte = CTL_CR; end
                        CH_T:      begin pre_emit = 1'b1; pre_res.dbyte = CTL_HT; end
                        CH_V:      begin pre_emit = 1'b1; pre_res.dbyte = CTL_VT; end
                        CH_BSLASH: begin pre_emit = 1'b1; pre_res.dbyte = CH_BSLASH; end
                        CH_DQUOTE: begin pre_emit = 1'b1; pre_res.dbyte = CH_DQUOTE; end
                        CH_SQUOTE: begin pre_emit = 1'b1; pre_res.dbyte = CH_SQUOTE; end
                        CH_X:      begin n_phase = PH_HEX1; end
                        default: begin
                            if (oct) begin
                                n_acc   = {5'd0, r_text[2:0]};
                                n_phase = PH_OCT1;
                            end else begin
                                // unknown escape: drop the backslash
                                use_body = 1'b1;
                            end
                        end
                    endcase
                    if (pre_emit) begin
                        n_phase = PH_BODY;
                    end
                end
                PH_HEX1: begin
                    if (hx[4]) begin
                        n_acc   = {4'd0, hx[3:0]};
                        n_phase = PH_HEX2;
                    end else begin
                        // lone \x gives the letter itself
                        pre_emit = 1'b1;
                        pre_res  = '{dbyte: CH_X, kind: KIND_BYTE, last: 1'b0};
                        use_body = 1'b1;
                    end
                end
                PH_HEX2: begin
                    pre_emit = 1'b1;
                    n_acc    = 8'd0;
                    if (hx[4]) begin
                        pre_res = '{dbyte: {r_acc[3:0], hx[3:0]}, kind: KIND_BYTE, last: 1'b0};
                        n_phase = PH_BODY;
                    end else begin
                        pre_res  = '{dbyte: r_acc, kind: KIND_BYTE, last: 1'b0};
                        use_body = 1'b1;
                    end
                end
                PH_OCT1: begin
                    if (oct) begin
                        n_acc   = {r_acc[4:0], r_text[2:0]};
                        n_phase = PH_OCT2;
                    end else begin
                        pre_emit = 1'b1;
                        pre_res  = '{dbyte: r_acc, kind: KIND_BYTE, last: 1'b0};
                        n_acc    = 8'd0;
                        use_body = 1'b1;
                    end
                end
                PH_OCT2: begin
                    pre_emit = 1'b1;
                    n_acc    = 8'd0;
                    if (oct) begin
                        // three digits: keep the low eight bits
                        pre_res = '{dbyte: {r_acc[4:0], r_text[2:0]}, kind: KIND_BYTE,
                                    last: 1'b0};
                        n_phase = PH_BODY;
                    end else begin
                        pre_res  = '{dbyte: r_acc, kind: KIND_BYTE, last: 1'b0};
                        use_body = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            if (use_body) begin
                n_phase = b_phase;
                if (b_clr) begin
                    n_acc = 8'd0;
                end
            end
        end
    end

    // Pack up to two results, the escape result first
    always_comb begin
        push.cnt  = 2'd0;
        push.res0 = pre_res;
        push.res1 = b_res;
        if (pre_emit) begin
            push.cnt = (use_body && b_emit) ? 2'd2 : 2'd1;
        end else if (use_body) begin
            push.res0 = b_res;
            push.cnt  = b_emit ? 2'd1 : 2'd0;
        end
        if (!fire) begin
            push.cnt = 2'd0;
        end
    end

    assign o_push = push;

    // Hold the input word and the escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_acc      <= 8'd0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
            end
        end
        if (o_ready && i_valid) begin
            r_text  <= i_text;
            r_start <= i_start;
        end
    end

endmodule

`default_nettype wire

>>> sv/slu_resq.sv
// Four-entry result queue taking up to two words a cycle and giving one.
`default_nettype none

`include "string_literal_unescape_macros.svh"

module slu_resq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  slu_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_ready,
    output slu_pkg::t_res      o_res
);
    import slu_pkg::*;

    t_res       r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_count <= 3'd2);
    assign o_res   = r_mem[r_rp];

    // Write incoming results
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_push.res1;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wp    <= r_wp + i_push.cnt;
            r_rp    <= r_rp + {1'b0, pop};
            r_count <= r_count + {1'b0, i_push.cnt} - {2'd0, pop};
        end
    end

    `SLU_ASSERT(a_count_max, r_count <= 3'd4, "result queue count above depth")
    `SLU_ASSERT(a_push_room, (i_push.cnt == 2'd0) || (r_count <= 3'd2), "push without room")
    `SLU_ASSERT_NEXT(a_count_hold, (i_push.cnt == 2'd0) && !pop, $stable(r_count), "count moved while idle")

endmodule

`default_nettype wire

>>> sv/string_literal_unescape.sv
// Top level of the string literal unescape decoder.
// Use: source text enters one byte per word on the slave channel; tuser set marks
// the first byte of a literal and restarts the decoder. A first byte that is not a
// double quote gives one word of kind "not a literal". Otherwise the body is
// decoded and each character leaves as a word of kind "byte" on the master
// channel; a closing quote or NUL gives a word of kind "end". tlast is set on end
// and not-a-literal words.
// Path: an accepted byte waits in the decoder's input register, is decoded from
// there and its results are written into the result queue, which offers them.
// Throughput: one byte per cycle while the queue has room; a byte that closes a
// hex or octal escape early can give two words, which the single output port
// gives one at a time. The four-word result queue sets the pace: the decoder
// fires while at most two words wait.
// Reset: the decoder returns to idle outside any literal and the queue empties.
// Stall: when the receiver drops tready the queue fills, the decoder holds its
// input word and tready on the slave side falls; nothing is lost.
`default_nettype none

module string_literal_unescape (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  wire logic       i_s_tuser,   // [0] start_flag
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] decoded_byte
    output logic [1:0]      o_m_tuser,   // [1:0] result_kind
    output logic            o_m_tlast    // last_of_run
);
    import slu_pkg::*;

    t_push push;
    logic  room;
    t_res  res;

    slu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_text  (i_s_tdata),
        .i_start (i_s_tuser),
        .i_room  (room),
        .o_push  (push)
    );

    slu_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    // Drive the output word fields
    assign o_m_tdata = res.dbyte;
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

endmodule

`default_nettype wire

>>> sim/slu_decode_checker.sv
// Checker for the string literal unescape block: decodes the accepted text itself and compares words.
module slu_decode_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] text_byte
    input  wire logic       i_s_tuser,   // [0] start_flag
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [7:0] decoded_byte
    input  wire logic [1:0] i_m_tuser,   // [1:0] result_kind
    input  wire logic       i_m_tlast,   // last_of_run
    output int              o_fail_count,
    output int              o_words_due
);
    import slu_pkg::*;

    // Where the decoder stands within the source text
    typedef enum logic [2:0] {
        OUTSIDE,
        IN_BODY,
        AFTER_BSLASH,
        HEX_FIRST,
        HEX_SECOND,
        OCT_FIRST,
        OCT_SECOND
    } t_scan;

    t_scan      scan = OUTSIDE;
    logic [7:0] escape_val = 8'h00;
    t_res       decoded_q[$];

    // Count a mismatch and print one line for it
    task report_mismatch(input string field, input logic [7:0] got, input logic [7:0] want);
        o_fail_count++;
        $display("%0t: %s mismatch, got %h want %h", $time, field, got, want);
    endtask

    function void push_word(input logic [7:0] dbyte, input t_kind kind, input logic last);
        t_res w;
        w.dbyte = dbyte;
        w.kind  = kind;
        w.last  = last;
        decoded_q.push_back(w);
    endfunction

    // Value of a hex digit; returns 0 when the byte is not one
    function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = c - (CH_LA - 8'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - (CH_UA - 8'd10);
        end else begin
            v = 4'h0;
            return 1'b0;
        end
        v = d[3:0];
        return 1'b1;
    endfunction

    // Character named by a one-letter escape; returns 0 for any other letter
    function bit simple_escape(input logic [7:0] c, output logic [7:0] ctl);
        ctl = c;
        case (c)
            CH_N:      ctl = CTL_LF;
            CH_R:      ctl = CTL_CR;
            CH_T:      ctl = CTL_HT;
            CH_V:      ctl = CTL_VT;
            CH_BSLASH,
            CH_DQUOTE,
            CH_SQUOTE: ctl = c;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Ordinary byte inside the literal body
    function void take_body(input logic [7:0] c);
        if (c == CH_BSLASH) begin
            scan = AFTER_BSLASH;
        end else if (c == CH_DQUOTE || c == CH_NUL) begin
            push_word(8'h00, KIND_END, 1'b1);
            scan       = OUTSIDE;
            escape_val = 8'h00;
        end else begin
            push_word(c, KIND_BYTE, 1'b0);
            scan = IN_BODY;
        end
    endfunction

    // Flush a pending escape value, then treat the byte as body text
    function void close_escape(input logic [7:0] c);
        push_word(escape_val, KIND_BYTE, 1'b0);
        escape_val = 8'h00;
        take_body(c);
    endfunction

    // Advance the decoder by one text byte and queue the words it yields
    function void unescape_byte(input logic [7:0] c, input logic first);
        logic [3:0] nib;
        logic [7:0] ctl;
        if (first) begin
            escape_val = 8'h00;
            if (c == CH_DQUOTE) begin
                scan = IN_BODY;
            end else begin
                scan = OUTSIDE;
                push_word(8'h00, KIND_NOTLIT, 1'b1);
            end
            return;
        end
        case (scan)
            IN_BODY: take_body(c);
            AFTER_BSLASH: begin
                if (c == CH_X) begin
                    scan = HEX_FIRST;
                end else if (c >= CH_0 && c <= CH_7) begin
                    escape_val = {5'd0, c[2:0]};
                    scan       = OCT_FIRST;
                end else if (simple_escape(c, ctl)) begin
                    push_word(ctl, KIND_BYTE, 1'b0);
                    scan = IN_BODY;
                end else begin
                    take_body(c);
                end
            end
            HEX_FIRST: begin
                if (hex_nibble(c, nib)) begin
                    escape_val = {4'h0, nib};
                    scan       = HEX_SECOND;
                end else begin
                    push_word(CH_X, KIND_BYTE, 1'b0);
                    take_body(c);
                end
            end
            HEX_SECOND: begin
                if (hex_nibble(c, nib)) begin
                    push_word({escape_val[3:0], nib}, KIND_BYTE, 1'b0);
                    escape_val = 8'h00;
                    scan       = IN_BODY;
                end else begin
                    close_escape(c);
                end
            end
            OCT_FIRST: begin
                if (c >= CH_0 && c <= CH_7) begin
                    escape_val = {escape_val[4:0], c[2:0]};
                    scan       = OCT_SECOND;
                end else begin
                    close_escape(c);
                end
            end
            OCT_SECOND: begin
                if (c >= CH_0 && c <= CH_7) begin
                    // third digit: keep the low eight bits only
                    push_word({escape_val[4:0], c[2:0]}, KIND_BYTE, 1'b0);
                    escape_val = 8'h00;
                    scan       = IN_BODY;
                end else begin
                    close_escape(c);
                end
            end
            default: scan = OUTSIDE;
        endcase
    endfunction

    // Compare words leaving the block, then decode words entering it
    always @(posedge i_clk) begin : watch_words
        t_res want;
        if (!i_rst_n) begin
            scan       = OUTSIDE;
            escape_val = 8'h00;
            decoded_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected word", i_m_tdata, 8'h00);
                end else begin
                    want = decoded_q.pop_front();
                    if (i_m_tdata !== want.dbyte) begin
                        report_mismatch("decoded_byte", i_m_tdata, want.dbyte);
                    end
                    if (i_m_tuser !== want.kind) begin
                        report_mismatch("result_kind", {6'd0, i_m_tuser}, {6'd0, want.kind});
                    end
                    if (i_m_tlast !== want.last) begin
                        report_mismatch("last_of_run", {7'd0, i_m_tlast}, {7'd0, want.last});
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                unescape_byte(i_s_tdata, i_s_tuser);
            end
        end
        o_words_due = decoded_q.size();
    end

endmodule

>>> sim/tb_string_literal_unescape.sv
// Testbench top for the string literal unescape block: text stimulus, receiver stalls, verdict.
module tb_string_literal_unescape;
    import slu_pkg::*;

    localparam int TEXT_WORDS = 1650;
    // Cycles without any accepted word before the run is declared hung
    localparam int IDLE_LIMIT = 2000;

    // Receiver stall patterns
    localparam int RX_OPEN     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] text_byte
    logic       i_s_tuser  = 1'b0;    // [0] start_flag
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;            // [7:0] decoded_byte
    logic [1:0] o_m_tuser;            // [1:0] result_kind
    logic       o_m_tlast;            // last_of_run

    int fail_count;
    int words_due;
    int text_sent    = 0;
    int burst_left   = 0;
    int stall_mode   = RX_OPEN;
    int stall_left   = 0;
    int stall_tick   = 0;
    int quiet_cycles = 0;

    string_literal_unescape dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    slu_decode_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stall the receiver on a randomly chosen pattern, picked anew when the current one runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(RX_OPEN, RX_PERIODIC);
            stall_left <= $urandom_range(20, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_tready <= ((stall_tick % 8) < 3);
        endcase
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one text word, hold it until taken, then maybe pause between bursts
    task automatic send_text(input logic first, input logic [7:0] b, input bit tally);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= first;
        do @(posedge i_clk); while (!o_s_tready);
        if (tally) text_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return 8'(CH_0 + v);
        if (v < 16) return 8'(CH_LA + (v - 10));
        return 8'(CH_UA + (v - 16));
    endfunction

    // Body text: often digit-like, so that short escapes end on a near miss
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        if ($urandom_range(0, 2) == 0) return hex_char();
        b = 8'($urandom_range(1, 255));
        if (b == CH_BSLASH || b == CH_DQUOTE) b = CH_LA;
        return b;
    endfunction

    function automatic logic [7:0] simple_char();
        case ($urandom_range(0, 6))
            0:       return CH_N;
            1:       return CH_R;
            2:       return CH_T;
            3:       return CH_V;
            4:       return CH_BSLASH;
            5:       return CH_DQUOTE;
            default: return CH_SQUOTE;
        endcase
    endfunction

    // One literal with random body; sometimes cut short by the next start
    task automatic send_literal();
        int tokens;
        int pick;
        int digits;
        send_text(1'b1, CH_DQUOTE, 1'b1);
        tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
        repeat (tokens) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_text(1'b0, plain_char(), 1'b1);
            end else begin
                send_text(1'b0, CH_BSLASH, 1'b1);
                if (pick < 55) begin
                    send_text(1'b0, simple_char(), 1'b1);
                end else if (pick < 70) begin
                    send_text(1'b0, CH_X, 1'b1);
                    digits = $urandom_range(0, 2);
                    repeat (digits) send_text(1'b0, hex_char(), 1'b1);
                end else if (pick < 85) begin
                    digits = $urandom_range(1, 3);
                    repeat (digits) send_text(1'b0, 8'(CH_0 + $urandom_range(0, 7)), 1'b1);
                end else if (pick < 95) begin
                    send_text(1'b0, 8'($urandom_range(1, 255)), 1'b1);
                end else begin
                    // drop the open escape: the next start restarts
                    return;
                end
            end
        end
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            send_text(1'b0, CH_DQUOTE, 1'b1);
        end else if (pick < 17) begin
            send_text(1'b0, CH_NUL, 1'b1);
        end else if (pick < 18) begin
            send_text(1'b0, CH_BSLASH, 1'b1);
            send_text(1'b0, CH_NUL, 1'b1);
        end
    endtask

    // Start on a byte that is not a quote, then stray bytes the block ignores
    task automatic send_noise();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_DQUOTE) b = CH_NUL;
        send_text(1'b1, b, 1'b1);
        repeat ($urandom_range(0, 3)) send_text(1'b0, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // not a literal, then a stray byte outside any literal
        send_text(1'b1, "A", 1'b1);
        send_text(1'b0, "z", 1'b1);
        // open, top byte value, newline escape
        send_text(1'b1, CH_DQUOTE, 1'b1);
        send_text(1'b0, 8'hFF, 1'b1);
        send_text(1'b0, CH_BSLASH, 1'b1);
        send_text(1'b0, CH_N, 1'b1);
        // two hex digits, mixed case
        send_text(1'b0, CH_BSLASH, 1'b1);
        send_text(1'b0, CH_X, 1'b1);
        send_text(1'b0, "A", 1'b1);
        send_text(1'b0, "f", 1'b1);
        // three octal digits that overflow eight bits
        send_text(1'b0, CH_BSLASH, 1'b1);
        send_text(1'b0, CH_7, 1'b1);
        send_text(1'b0, CH_7, 1'b1);
        send_text(1'b0, CH_7, 1'b1);
        // lone hex escape, then an unknown escape
        send_text(1'b0, CH_BSLASH, 1'b1);
        send_text(1'b0, CH_X, 1'b1);
        send_text(1'b0, "g", 1'b1);
        send_text(1'b0, CH_BSLASH, 1'b1);
        send_text(1'b0, "q", 1'b1);
        // one hex digit ended by the closing quote: two words in one step
        send_text(1'b0, CH_BSLASH, 1'b1);
        send_text(1'b0, CH_X, 1'b1);
        send_text(1'b0, "5", 1'b1);
        send_text(1'b0, CH_DQUOTE, 1'b1);
        // restart inside an octal escape, then NUL after a backslash
        send_text(1'b1, CH_DQUOTE, 1'b1);
        send_text(1'b0, CH_BSLASH, 1'b1);
        send_text(1'b0, "3", 1'b1);
        send_text(1'b1, CH_DQUOTE, 1'b1);
        send_text(1'b0, CH_BSLASH, 1'b1);
        send_text(1'b0, CH_NUL, 1'b1);

        // random literals, with some noise between them
        while (text_sent < TEXT_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_noise();
            end else begin
                send_literal();
            end
        end
        i_s_tvalid <= 1'b0;

        // drain, then allow for stray words
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && words_due == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
